/* src/dihedral_angle_unit_macros.svh */
// Assertion macros shared by the dihedral angle unit.
`ifndef DIHEDRAL_ANGLE_UNIT_MACROS_SVH
`define DIHEDRAL_ANGLE_UNIT_MACROS_SVH
// Checks a property on every clock edge outside reset.
`define DAU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checks that a condition in one cycle implies another in the next.
`define DAU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

/* src/dau_pkg.sv */
// Package with widths, payload types and the arctangent table of the dihedral angle unit.
`timescale 1ns / 1ps
package dau_pkg;
	localparam int COORD_W      = 32;
	localparam int IN_W         = 12 * COORD_W;
	localparam int ANGLE_BITS   = 16;
	localparam int ANG_W        = 32;
	localparam int ANG_SH       = ANG_W - ANGLE_BITS;
	localparam int OUT_W        = ((ANGLE_BITS + 7) / 8) * 8;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int MANT_W       = 21;
	localparam int BLEN_W       = $clog2(DIFF_W + 1);
	localparam int SHF_W        = 4;
	localparam int PRD_W        = 2 * MANT_W;
	localparam int CRS_W        = PRD_W + 1;
	localparam int SUM_W        = PRD_W;
	localparam int YD_W         = 64;
	localparam int CLO_W        = 22;
	localparam int CHI_W        = CRS_W - CLO_W;
	localparam int WIDE_W       = 98;
	localparam int LEN_FRAC     = 10;
	localparam int RAD_W        = SUM_W + 2 * LEN_FRAC;
	localparam int SQRT_STEPS   = RAD_W / 2;
	localparam int LEN_W        = SQRT_STEPS;
	localparam int REM_W        = LEN_W + 4;
	localparam int MAG_W        = 128;
	localparam int NRM_W        = 40;
	localparam int CORD_W       = NRM_W + 3;
	localparam int CORDIC_STEPS = 30;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [MANT_W-1:0]  mant_t;
	typedef logic signed [WIDE_W-1:0]  wide_t;

	typedef struct packed {
		mant_t [2:0] b1;
		mant_t [2:0] b2;
		mant_t [2:0] b3;
	} bond_t;

	typedef struct packed {
		logic [SUM_W-1:0]        sq;
		logic signed [YD_W-1:0]  ydot;
		logic signed [WIDE_W-1:0] x;
	} prod_t;

	typedef struct packed {
		logic [LEN_W-1:0]        len;
		logic signed [YD_W-1:0]  ydot;
		logic signed [WIDE_W-1:0] x;
	} sqr_t;

	typedef struct packed {
		logic [NRM_W-1:0] mx;
		logic [NRM_W-1:0] my;
		logic             xneg;
		logic             yneg;
		logic             zero;
	} nrm_t;

	function automatic logic [ANG_W-1:0] atan_ang(input int i);
		logic [ANG_W-1:0] r;
		case (i)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2F9;
			15: r = 32'h0000517C;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A2F;
			19: r = 32'h00000517;
			20: r = 32'h0000028B;
			21: r = 32'h00000145;
			22: r = 32'h000000A2;
			23: r = 32'h00000051;
			24: r = 32'h00000028;
			25: r = 32'h00000014;
			26: r = 32'h0000000A;
			27: r = 32'h00000005;
			28: r = 32'h00000002;
			29: r = 32'h00000001;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

/* src/dau_bond.sv */
// Bond vector stages: differences, common exponent and mantissa shift.
`timescale 1ns / 1ps
module dau_bond (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_i,
	input  logic [dau_pkg::IN_W-1:0] pts_i,
	output logic                    vld_o,
	output dau_pkg::bond_t          bond_o
);
	import dau_pkg::*;

	typedef logic signed [DIFF_W-1:0] diff_t;

	logic             vld_s1, vld_s2, vld_s3;
	diff_t            d_n [3][3];
	diff_t            d_s1 [3][3];
	diff_t            d_s2 [3][3];
	logic [SHF_W-1:0] sh_n [3];
	logic [SHF_W-1:0] sh_s2 [3];
	bond_t            bond_n;
	bond_t            bond_s3;

	always_comb begin
		for (int v = 0; v < 3; v++) begin
			for (int k = 0; k < 3; k++) begin
				d_n[v][k] = diff_t'(coord_t'(pts_i[((v + 1) * 3 + k) * COORD_W +: COORD_W]))
					- diff_t'(coord_t'(pts_i[(v * 3 + k) * COORD_W +: COORD_W]));
			end
		end
	end

	always_comb begin
		logic [DIFF_W-1:0] orv;
		logic [BLEN_W-1:0] blen;
		for (int v = 0; v < 3; v++) begin
			orv = '0;
			for (int k = 0; k < 3; k++) begin
				orv |= d_s1[v][k][DIFF_W-1] ? unsigned'(-d_s1[v][k]) : unsigned'(d_s1[v][k]);
			end
			blen = '0;
			for (int j = 0; j < DIFF_W; j++) begin
				if (orv[j]) begin
					blen = BLEN_W'(j + 1);
				end
			end
			sh_n[v] = (blen > BLEN_W'(MANT_W - 1)) ? SHF_W'(blen - BLEN_W'(MANT_W - 1)) : '0;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			bond_n.b1[k] = mant_t'(d_s2[0][k] >>> sh_s2[0]);
			bond_n.b2[k] = mant_t'(d_s2[1][k] >>> sh_s2[1]);
			bond_n.b3[k] = mant_t'(d_s2[2][k] >>> sh_s2[2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= d_n;
			d_s2    <= d_s1;
			sh_s2   <= sh_n;
			bond_s3 <= bond_n;
		end
	end

	assign vld_o  = vld_s3;
	assign bond_o = bond_s3;
endmodule

/* src/dau_prod.sv */
// Cross products, dot products and the squared length of the middle bond.
`timescale 1ns / 1ps
module dau_prod (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_i,
	input  dau_pkg::bond_t bond_i,
	output logic           vld_o,
	output dau_pkg::prod_t prod_o
);
	import dau_pkg::*;

	typedef logic signed [PRD_W-1:0]         prd_t;
	typedef logic signed [CRS_W-1:0]         crs_t;
	typedef logic signed [YD_W-1:0]          yd_t;
	typedef logic signed [CRS_W+CHI_W-1:0]   xh_t;
	typedef logic signed [CRS_W+CLO_W:0]     xl_t;

	logic             vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	prd_t             pc_s1 [6];
	prd_t             pn_s1 [6];
	prd_t             sq_s1 [3];
	mant_t            b1_s1 [3];
	crs_t             c_s2 [3];
	crs_t             n_s2 [3];
	logic [SUM_W-1:0] sq_s2, sq_s3, sq_s4, sq_s5;
	mant_t            b1_s2 [3];
	yd_t              yp_s3 [3];
	xh_t              xh_s3 [3];
	xl_t              xl_s3 [3];
	yd_t              ydot_s4, ydot_s5;
	wide_t            xt_s4 [3];
	wide_t            x_s5;
	logic signed [YD_W+1:0] ysum;

	assign ysum = (YD_W+2)'(yp_s3[0]) + (YD_W+2)'(yp_s3[1]) + (YD_W+2)'(yp_s3[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pc_s1[2*k]   <= prd_t'(bond_i.b2[(k + 1) % 3]) * prd_t'(bond_i.b3[(k + 2) % 3]);
				pc_s1[2*k+1] <= prd_t'(bond_i.b2[(k + 2) % 3]) * prd_t'(bond_i.b3[(k + 1) % 3]);
				pn_s1[2*k]   <= prd_t'(bond_i.b1[(k + 1) % 3]) * prd_t'(bond_i.b2[(k + 2) % 3]);
				pn_s1[2*k+1] <= prd_t'(bond_i.b1[(k + 2) % 3]) * prd_t'(bond_i.b2[(k + 1) % 3]);
				sq_s1[k]     <= prd_t'(bond_i.b2[k]) * prd_t'(bond_i.b2[k]);
				b1_s1[k]     <= bond_i.b1[k];
				c_s2[k]      <= crs_t'(pc_s1[2*k]) - crs_t'(pc_s1[2*k+1]);
				n_s2[k]      <= crs_t'(pn_s1[2*k]) - crs_t'(pn_s1[2*k+1]);
				b1_s2[k]     <= b1_s1[k];
				yp_s3[k]     <= yd_t'(b1_s2[k]) * yd_t'(c_s2[k]);
				xh_s3[k]     <= xh_t'(n_s2[k]) * xh_t'(signed'(c_s2[k][CRS_W-1:CLO_W]));
				xl_s3[k]     <= xl_t'(n_s2[k]) * xl_t'(signed'({1'b0, c_s2[k][CLO_W-1:0]}));
				xt_s4[k]     <= (wide_t'(xh_s3[k]) <<< CLO_W) + wide_t'(xl_s3[k]);
			end
			sq_s2   <= unsigned'(sq_s1[0]) + unsigned'(sq_s1[1]) + unsigned'(sq_s1[2]);
			sq_s3   <= sq_s2;
			sq_s4   <= sq_s3;
			sq_s5   <= sq_s4;
			ydot_s4 <= ysum[YD_W-1:0];
			ydot_s5 <= ydot_s4;
			x_s5    <= (xt_s4[0] + xt_s4[1] + xt_s4[2]) <<< LEN_FRAC;
		end
	end

	assign vld_o       = vld_s5;
	assign prod_o.sq   = sq_s5;
	assign prod_o.ydot = ydot_s5;
	assign prod_o.x    = x_s5;
endmodule

/* src/dau_isqrt.sv */
// Pipelined integer square root, two radicand bits per stage, with the dot products carried along.
`timescale 1ns / 1ps
module dau_isqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_i,
	input  dau_pkg::prod_t prod_i,
	output logic           vld_o,
	output dau_pkg::sqr_t  sqr_o
);
	import dau_pkg::*;

	logic [SQRT_STEPS-1:0] vld_s;
	logic [REM_W-1:0]      rem_s  [SQRT_STEPS];
	logic [LEN_W-1:0]      root_s [SQRT_STEPS];
	logic [RAD_W-1:0]      rad_s  [SQRT_STEPS];
	prod_t                 pay_s  [SQRT_STEPS];

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
		logic             vld_in;
		logic [REM_W-1:0] rem_in;
		logic [LEN_W-1:0] root_in;
		logic [RAD_W-1:0] rad_in;
		prod_t            pay_in;
		logic [REM_W-1:0] rsh, trial;
		logic             ge;

		if (g == 0) begin : g_first
			assign vld_in  = vld_i;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = {prod_i.sq, {(2 * LEN_FRAC){1'b0}}};
			assign pay_in  = prod_i;
		end else begin : g_next
			assign vld_in  = vld_s[g-1];
			assign rem_in  = rem_s[g-1];
			assign root_in = root_s[g-1];
			assign rad_in  = rad_s[g-1];
			assign pay_in  = pay_s[g-1];
		end

		assign rsh   = {rem_in[REM_W-3:0], rad_in[RAD_W-1-2*g -: 2]};
		assign trial = REM_W'({root_in, 2'b01});
		assign ge    = rsh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= ge ? rsh - trial : rsh;
				root_s[g] <= {root_in[LEN_W-2:0], ge};
				rad_s[g]  <= rad_in;
				pay_s[g]  <= pay_in;
			end
		end
	end

	assign vld_o      = vld_s[SQRT_STEPS-1];
	assign sqr_o.len  = root_s[SQRT_STEPS-1];
	assign sqr_o.ydot = pay_s[SQRT_STEPS-1].ydot;
	assign sqr_o.x    = pay_s[SQRT_STEPS-1].x;
endmodule

/* src/dau_norm.sv */
// Scales the sine term by the bond length, takes magnitudes and normalizes both arctangent arguments.
`timescale 1ns / 1ps
module dau_norm (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  dau_pkg::sqr_t sqr_i,
	output logic          vld_o,
	output dau_pkg::nrm_t nrm_o
);
	import dau_pkg::*;

	typedef logic signed [2*(YD_W/2)-1:0] ph_t;
	typedef logic signed [2*(YD_W/2):0]   pl_t;

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	ph_t                ph_s1;
	pl_t                pl_s1;
	wide_t              x_s1, x_s2, y_s2;
	logic [MAG_W-1:0]   mx_s3, my_s3, mx_s4, my_s4, mx_s5, my_s5;
	logic [2*MAG_W-1:0] st4_n, st5_n, st6_n;
	logic [2:0]         flg_s3, flg_s4, flg_s5;
	nrm_t               nrm_s6;

	function automatic logic [2*MAG_W-1:0] lz_step(input logic [2*MAG_W-1:0] ab, input int k);
		logic [MAG_W-1:0] a, b;
		a = ab[2*MAG_W-1:MAG_W];
		b = ab[MAG_W-1:0];
		if (((a | b) >> (MAG_W - k)) == '0) begin
			a = a << k;
			b = b << k;
		end
		return {a, b};
	endfunction

	assign st4_n = lz_step(lz_step({mx_s3, my_s3}, 64), 32);
	assign st5_n = lz_step(lz_step(lz_step({mx_s4, my_s4}, 16), 8), 4);
	assign st6_n = lz_step(lz_step({mx_s5, my_s5}, 2), 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1 <= ph_t'(signed'(sqr_i.ydot[YD_W-1:YD_W/2])) * ph_t'(signed'({1'b0, sqr_i.len}));
			pl_s1 <= pl_t'(signed'({1'b0, sqr_i.ydot[YD_W/2-1:0]}))
				* pl_t'(signed'({1'b0, sqr_i.len}));
			x_s1  <= sqr_i.x;
			y_s2  <= (wide_t'(ph_s1) <<< (YD_W / 2)) + wide_t'(pl_s1);
			x_s2  <= x_s1;
			mx_s3 <= MAG_W'(unsigned'(x_s2[WIDE_W-1] ? -x_s2 : x_s2));
			my_s3 <= MAG_W'(unsigned'(y_s2[WIDE_W-1] ? -y_s2 : y_s2));
			flg_s3 <= {x_s2[WIDE_W-1], y_s2[WIDE_W-1], (x_s2 == '0) && (y_s2 == '0)};
			{mx_s4, my_s4} <= st4_n;
			flg_s4 <= flg_s3;
			{mx_s5, my_s5} <= st5_n;
			flg_s5 <= flg_s4;
			nrm_s6.mx   <= st6_n[2*MAG_W-1 -: NRM_W];
			nrm_s6.my   <= st6_n[MAG_W-1 -: NRM_W];
			nrm_s6.xneg <= flg_s5[2];
			nrm_s6.yneg <= flg_s5[1];
			nrm_s6.zero <= flg_s5[0];
		end
	end

	assign vld_o = vld_s6;
	assign nrm_o = nrm_s6;
endmodule

/* src/dau_cordic.sv */
// Vectoring CORDIC, one rotation per stage, with quadrant fold and output rounding.
`timescale 1ns / 1ps
`include "dihedral_angle_unit_macros.svh"
module dau_cordic (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_i,
	input  dau_pkg::nrm_t               nrm_i,
	output logic                        vld_o,
	output logic [dau_pkg::ANGLE_BITS-1:0] ang_o
);
	import dau_pkg::*;

	typedef logic signed [CORD_W-1:0] cw_t;

	localparam int LAST = CORDIC_STEPS - 1;

	logic [CORDIC_STEPS-1:0] vld_s;
	cw_t                     x_s [CORDIC_STEPS];
	cw_t                     y_s [CORDIC_STEPS];
	logic [ANG_W-1:0]        z_s [CORDIC_STEPS];
	logic [2:0]              flg_s [CORDIC_STEPS];
	logic                    vld_q;
	logic [ANGLE_BITS-1:0]   ang_q;
	logic [ANGLE_BITS-1:0]   ang_n;

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
		logic             vld_in;
		cw_t              x_in, y_in, dx, dy;
		logic [ANG_W-1:0] z_in;
		logic [2:0]       flg_in;

		if (g == 0) begin : g_first
			assign vld_in = vld_i;
			assign x_in   = cw_t'(nrm_i.mx);
			assign y_in   = cw_t'(nrm_i.my);
			assign z_in   = '0;
			assign flg_in = {nrm_i.xneg, nrm_i.yneg, nrm_i.zero};
		end else begin : g_next
			assign vld_in = vld_s[g-1];
			assign x_in   = x_s[g-1];
			assign y_in   = y_s[g-1];
			assign z_in   = z_s[g-1];
			assign flg_in = flg_s[g-1];
		end

		assign dx = x_in >>> g;
		assign dy = y_in >>> g;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_in[CORD_W-1]) begin
					x_s[g] <= x_in + dy;
					y_s[g] <= y_in - dx;
					z_s[g] <= z_in + atan_ang(g);
				end else begin
					x_s[g] <= x_in - dy;
					y_s[g] <= y_in + dx;
					z_s[g] <= z_in - atan_ang(g);
				end
				flg_s[g] <= flg_in;
			end
		end
	end

	always_comb begin
		logic [ANG_W-1:0] zf, zr;
		zf = flg_s[LAST][2] ? (ANG_W'(1) << (ANG_W - 1)) - z_s[LAST] : z_s[LAST];
		if (flg_s[LAST][1]) begin
			zf = '0 - zf;
		end
		zr    = zf + (ANG_W'(1) << (ANG_SH - 1));
		ang_n = flg_s[LAST][0] ? '0 : zr[ANG_W-1:ANG_SH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_q <= ang_n;
		end
	end

	assign vld_o = vld_q;
	assign ang_o = ang_q;

	`DAU_ASSERT(a_norm_top, (vld_i && !nrm_i.zero) |-> (nrm_i.mx[NRM_W-1] || nrm_i.my[NRM_W-1]), "nonzero item reached the CORDIC without a normalized top bit")
	`DAU_ASSERT(a_x_nonneg, vld_s[LAST] |-> !x_s[LAST][CORD_W-1], "CORDIC x went negative")
	`DAU_ASSERT_NEXT(a_zero_out, en && vld_s[LAST] && flg_s[LAST][0], ang_q == '0, "zero arguments gave a nonzero angle")
endmodule

/* src/dihedral_angle_unit.sv */
// Top level of the dihedral angle unit: stream ports and the pipeline chain.
`timescale 1ns / 1ps
// Computes the torsion angle of four 3-D points given as 32-bit signed fixed-point
// coordinates and returns it as a signed binary angle where the most negative code is -pi.
// The unit is fully pipelined: it takes one item per cycle while the output is not stalled,
// and each result passes through 3 bond stages, 5 product stages, a 31-stage square root
// of the middle bond length, 6 scaling and normalization stages, a 30-stage CORDIC and one
// output stage. The whole pipeline advances whenever the output register is empty or is
// being taken, so a stall on the output holds every item in place.
module dihedral_angle_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, p4_x, p4_y, p4_z from bit 0 up.
	input  logic [dau_pkg::IN_W-1:0]     s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// torsion_angle from bit 0 up, zero filled to whole bytes.
	output logic [dau_pkg::OUT_W-1:0]    m_tdata
);
	import dau_pkg::*;

	logic                  en;
	logic                  bond_vld, prod_vld, sqr_vld, nrm_vld, ang_vld;
	bond_t                 bond;
	prod_t                 prod;
	sqr_t                  sqr;
	nrm_t                  nrm;
	logic [ANGLE_BITS-1:0] ang;

	assign en       = !ang_vld || m_tready;
	assign s_tready = en;

	dau_bond u_bond (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(s_tvalid), .pts_i(s_tdata),
		.vld_o(bond_vld), .bond_o(bond)
	);

	dau_prod u_prod (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(bond_vld), .bond_i(bond),
		.vld_o(prod_vld), .prod_o(prod)
	);

	dau_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(prod_vld), .prod_i(prod),
		.vld_o(sqr_vld), .sqr_o(sqr)
	);

	dau_norm u_norm (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(sqr_vld), .sqr_i(sqr),
		.vld_o(nrm_vld), .nrm_o(nrm)
	);

	dau_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(nrm_vld), .nrm_i(nrm),
		.vld_o(ang_vld), .ang_o(ang)
	);

	assign m_tvalid = ang_vld;
	assign m_tdata  = OUT_W'(ang);
endmodule
